>>> rtl/rfst_pkg.sv
// rfst_pkg: shared types and constants for the recent frame slot table
// used by rfst_id_ram, rfst_ctrl and recent_frame_slot_table
`default_nettype none

package rfst_pkg;

  // table geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int SLOT_COUNT  = QUEUE_DEPTH + 1;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int ID_W     = 32;
  localparam int QUERY_W  = 64;
  localparam int CFG_W    = 16;
  localparam int STATUS_W = 3;

  // header check patterns
  localparam logic [ID_W-1:0] LEAD_PATTERN  = 32'haaaa_aaaa;
  localparam logic [ID_W-1:0] TRAIL_PATTERN = 32'h5555_5555;

  // request types
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_UNCONFIGURED = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_NOT_FOUND    = 3'd4
  } status_t;

  // request sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DUP,
    S_SCAN,
    S_DONE
  } state_t;

  // access to the id memory
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
  } ram_req_t;

  // finished result from the sequencer
  typedef struct packed {
    logic              vld;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/rfst_id_ram.sv
// rfst_id_ram: slot id store, one write port and one read port, registered read
// depends on rfst_pkg
`default_nettype none

module rfst_id_ram (
  input  logic                    clk,
  input  rfst_pkg::ram_req_t      req,
  output logic [rfst_pkg::ID_W-1:0] rd_data
);
  import rfst_pkg::*;

  logic [ID_W-1:0] mem [SLOT_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rfst_ctrl.sv
// rfst_ctrl: request sequencer, header checks, duplicate check and lookup scan
// depends on rfst_pkg; drives rfst_id_ram through a ram_req_t
`default_nettype none

module rfst_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [rfst_pkg::ID_W-1:0]    lead_word,
  input  logic [rfst_pkg::ID_W-1:0]    frame_id,
  input  logic [rfst_pkg::ID_W-1:0]    trail_word,
  input  logic [rfst_pkg::QUERY_W-1:0] query_id,
  input  logic                         cfg_ok,
  input  logic                         res_take,
  output rfst_pkg::ram_req_t           ram_req,
  input  logic [rfst_pkg::ID_W-1:0]    rd_data,
  output rfst_pkg::result_t            res
);
  import rfst_pkg::*;

  state_t state, state_next;

  // captured request
  logic              r_type;
  logic              r_hdr_ok;
  logic [ID_W-1:0]   r_id;
  logic [ID_W-1:0]   r_qlo;
  logic              r_qhi_zero;

  // table pointers
  logic [SLOT_W-1:0] next_slot;
  logic [CNT_W-1:0]  held_count;

  // scan state
  logic [SLOT_W-1:0] ptr;
  logic [CNT_W-1:0]  iss_cnt;
  logic              cmp_vld;
  logic [SLOT_W-1:0] cmp_slot;

  // result holding
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;

  // actions from the output block
  logic              do_commit;
  logic              do_issue;
  logic              set_res;
  status_t           res_status_next;
  logic [SLOT_W-1:0] res_slot_next;

  logic [SLOT_W-1:0] newest;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W:0]   oldest_sum;
  logic              dup_hit;
  logic              query_hit;
  logic              scan_done;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // ring positions of the newest and oldest held entries
  always_comb begin
    newest     = (next_slot == '0) ? SLOT_W'(SLOT_COUNT - 1) : next_slot - SLOT_W'(1);
    oldest_sum = {1'b0, next_slot} + (SLOT_W + 1)'(SLOT_COUNT)
                 - (SLOT_W + 1)'(held_count);
    oldest     = (oldest_sum >= (SLOT_W + 1)'(SLOT_COUNT))
                 ? SLOT_W'(oldest_sum - (SLOT_W + 1)'(SLOT_COUNT))
                 : SLOT_W'(oldest_sum);
  end

  // compares against the memory read data
  assign dup_hit   = (rd_data == r_id);
  assign query_hit = r_qhi_zero && (rd_data == r_qlo);
  assign scan_done = (iss_cnt == held_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (r_type == REQ_LOOKUP) begin
          state_next = (held_count == '0) ? S_DONE : S_SCAN;
        end else if (!cfg_ok || !r_hdr_ok || held_count == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DUP;
        end
      end
      S_DUP: begin
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (cmp_vld && (query_hit || scan_done)) state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath actions
  always_comb begin
    ram_req         = '0;
    do_commit       = 1'b0;
    do_issue        = 1'b0;
    set_res         = 1'b0;
    res_status_next = ST_OK;
    res_slot_next   = '0;
    unique case (state)
      S_IDLE: ;
      S_CHECK: begin
        if (r_type == REQ_LOOKUP) begin
          if (held_count == '0) begin
            set_res         = 1'b1;
            res_status_next = ST_NOT_FOUND;
          end
        end else if (!cfg_ok) begin
          set_res         = 1'b1;
          res_status_next = ST_UNCONFIGURED;
        end else if (!r_hdr_ok) begin
          set_res         = 1'b1;
          res_status_next = ST_BAD_HEADER;
        end else if (held_count == '0) begin
          // empty table skips the duplicate check
          ram_req.wr_en   = 1'b1;
          do_commit       = 1'b1;
          set_res         = 1'b1;
          res_slot_next   = next_slot;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = newest;
        end
      end
      S_DUP: begin
        set_res = 1'b1;
        if (dup_hit) begin
          res_status_next = ST_DUPLICATE;
        end else begin
          ram_req.wr_en = 1'b1;
          do_commit     = 1'b1;
          res_slot_next = next_slot;
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = ptr;
          do_issue        = 1'b1;
        end
        if (cmp_vld && query_hit) begin
          set_res       = 1'b1;
          res_slot_next = cmp_slot;
        end else if (cmp_vld && scan_done) begin
          set_res         = 1'b1;
          res_status_next = ST_NOT_FOUND;
        end
      end
      S_DONE: ;
      default: ;
    endcase
    ram_req.wr_addr = next_slot;
    ram_req.wr_data = r_id;
  end

  assign in_ready   = (state == S_IDLE);
  assign res.vld    = (state == S_DONE);
  assign res.status = res_status;
  assign res.slot   = res_slot;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_slot  <= '0;
      held_count <= '0;
      cmp_vld    <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= do_issue;
      if (do_commit) begin
        next_slot <= slot_inc(next_slot);
        if (held_count != CNT_W'(QUEUE_DEPTH)) begin
          held_count <= held_count + CNT_W'(1);
        end
      end
    end
  end

  // request capture, scan pointers and result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      r_type     <= req_type;
      r_hdr_ok   <= (lead_word == LEAD_PATTERN) && (trail_word == TRAIL_PATTERN);
      r_id       <= frame_id;
      r_qlo      <= query_id[ID_W-1:0];
      r_qhi_zero <= (query_id[QUERY_W-1:ID_W] == '0);
    end
    if (state == S_CHECK) begin
      ptr     <= oldest;
      iss_cnt <= '0;
    end else if (do_issue) begin
      ptr      <= slot_inc(ptr);
      iss_cnt  <= iss_cnt + CNT_W'(1);
    end
    if (do_issue) begin
      cmp_slot <= ptr;
    end
    if (set_res) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/recent_frame_slot_table.sv
// recent_frame_slot_table: ring of recent frame ids with add and lookup requests
// add: S_CHECK, then S_DUP if the newest id is read for the duplicate check, then S_DONE;
// lookup: S_CHECK goes straight to S_DONE on an empty table, else S_SCAN until a match
// or a miss (one memory read per held slot, oldest first, through the single read port)
// throughput: one request at a time; next request taken once the result sits in the
// output register; reset: synchronous rst empties the table and clears both size registers
// depends on rfst_pkg, rfst_ctrl and rfst_id_ram
`default_nettype none

module recent_frame_slot_table (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [rfst_pkg::ID_W-1:0]     lead_word,
  input  logic [rfst_pkg::ID_W-1:0]     frame_id,
  input  logic [rfst_pkg::ID_W-1:0]     trail_word,
  input  logic [rfst_pkg::QUERY_W-1:0]  query_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfst_pkg::STATUS_W-1:0] status,
  output logic [rfst_pkg::SLOT_W-1:0]   slot,
  // configuration writes
  input  logic                          cfg_en,
  input  logic                          cfg_index,
  input  logic [rfst_pkg::CFG_W-1:0]    cfg_data
);
  import rfst_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             cfg_ok;
  logic             in_fire;
  logic             res_take;
  ram_req_t         ram_req;
  logic [ID_W-1:0]  rd_data;
  result_t          res;

  // frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= '0;
      frame_height <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  assign cfg_ok   = (frame_width != '0) && (frame_height != '0);
  assign in_fire  = in_valid && in_ready;
  assign res_take = !out_valid || out_ready;

  rfst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .lead_word  (lead_word),
    .frame_id   (frame_id),
    .trail_word (trail_word),
    .query_id   (query_id),
    .cfg_ok     (cfg_ok),
    .res_take   (res_take),
    .ram_req    (ram_req),
    .rd_data    (rd_data),
    .res        (res)
  );

  rfst_id_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.vld && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld && res_take) begin
      status <= res.status;
      slot   <= res.slot;
    end
  end

  // a result never names a slot outside the pool
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (slot <= SLOT_W'(SLOT_COUNT - 1)))
    else $error("result slot outside the pool");

  // rejected and missed requests report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (slot == '0))
    else $error("nonzero slot on a failed request");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("request taken while another is in work");

endmodule

`default_nettype wire
